### rtl/core/bdpc_pkg.sv
// Types, constants and register indexes shared by the button debounce and press classifier.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package bdpc_pkg;

  localparam int unsigned NUM_BUTTONS_DEF   = 2;
  localparam int unsigned DURATION_BITS_DEF = 24;

  localparam int unsigned MAX_RES     = 4;
  localparam int unsigned REM_W       = $clog2(MAX_RES + 1);
  localparam int unsigned DUR_FIELD_W = 24;
  localparam int unsigned SINCE_W     = 10;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;

  localparam logic [SINCE_W-1:0]  DEBOUNCE_RST = 10'd50;
  localparam logic [15:0]         MEDIUM_RST   = 16'd600;
  localparam logic [15:0]         LONG_RST     = 16'd1500;

  typedef enum logic [1:0] {
    KIND_DOWN   = 2'd0,
    KIND_SHORT  = 2'd1,
    KIND_MEDIUM = 2'd2,
    KIND_LONG   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [SINCE_W-1:0] debounce_ms;
    logic [15:0]        medium_ms;
    logic [15:0]        long_ms;
  } cfg_t;

  typedef struct packed {
    logic                   vld;
    logic                   which;
    kind_e                  kind;
    logic [DUR_FIELD_W-1:0] dur;
  } evt_t;

  // Slot a is the older event; slot b is only valid when slot a is.
  typedef struct packed {
    evt_t a;
    evt_t b;
  } pair_t;

  typedef struct packed {
    logic load;
    logic flush;
    logic pop;
  } cell_ctl_t;

endpackage

### rtl/core/bdpc_btn_cell.sv
// One button cell: debounce state, press timing and a two-event slot in the drain chain.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_btn_cell import bdpc_pkg::*; #(
  parameter int unsigned CELL_IDX      = 0,
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      level_i,
  input  cfg_t      cfg_i,
  input  pair_t     upper_i,
  input  logic      lower_empty_i,
  output pair_t     pair_o,
  output logic      empty_o,
  output logic [1:0] count_o
);

  localparam logic WHICH = 1'(CELL_IDX % 2);

  logic                     raw_q, raw_d;
  logic                     stable_q, stable_d;
  logic [SINCE_W-1:0]       since_q, since_d;
  logic [DURATION_BITS-1:0] held_q, held_d, held_inc;
  logic                     long_q, long_d;
  logic [DUR_FIELD_W-1:0]   dur_sat;
  logic                     pressed_now;
  logic                     settled;
  evt_t                     ev_a, ev_b;
  pair_t                    fresh;
  pair_t                    pair_q, pair_d;

  assign pressed_now = ~level_i;
  assign held_inc    = (stable_q && (held_q != '1)) ? held_q + 1'b1 : held_q;

  if (DURATION_BITS > DUR_FIELD_W) begin : g_sat
    assign dur_sat = (|held_inc[DURATION_BITS-1:DUR_FIELD_W]) ? '1
                                                              : held_inc[DUR_FIELD_W-1:0];
  end else begin : g_ext
    assign dur_sat = DUR_FIELD_W'(held_inc);
  end

  always_comb begin
    raw_d    = raw_q;
    since_d  = since_q;
    stable_d = stable_q;
    held_d   = held_inc;
    long_d   = long_q;
    ev_a     = '0;
    ev_b     = '0;
    if (pressed_now != raw_q) begin
      raw_d   = pressed_now;
      since_d = '0;
    end else if (since_q != '1) begin
      since_d = since_q + 1'b1;
    end
    settled = (since_d >= cfg_i.debounce_ms);
    if (settled && (raw_d != stable_q)) begin
      stable_d = raw_d;
      if (raw_d) begin
        held_d    = '0;
        long_d    = 1'b0;
        ev_a.vld  = 1'b1;
        ev_a.which = WHICH;
        ev_a.kind = KIND_DOWN;
        ev_a.dur  = '0;
      end else if (!long_q) begin
        ev_a.vld  = 1'b1;
        ev_a.which = WHICH;
        ev_a.kind = (held_inc >= DURATION_BITS'(cfg_i.medium_ms)) ? KIND_MEDIUM : KIND_SHORT;
        ev_a.dur  = dur_sat;
      end
    end
    if (stable_d && !long_d && (held_d >= DURATION_BITS'(cfg_i.long_ms))) begin
      long_d     = 1'b1;
      ev_b.vld   = 1'b1;
      ev_b.which = WHICH;
      ev_b.kind  = KIND_LONG;
      ev_b.dur   = (held_d == '0) ? '0 : dur_sat;
    end
    if (ev_a.vld) begin
      fresh.a = ev_a;
      fresh.b = ev_b;
    end else begin
      fresh.a = ev_b;
      fresh.b = '0;
    end
  end

  assign count_o = {1'b0, ev_a.vld} + {1'b0, ev_b.vld};
  assign empty_o = !pair_q.a.vld;
  assign pair_o  = pair_q;

  always_comb begin
    pair_d = pair_q;
    priority if (ctl_i.load) begin
      pair_d = fresh;
    end else if (ctl_i.flush) begin
      pair_d = '0;
    end else if (empty_o) begin
      pair_d = upper_i;
    end else if (lower_empty_i) begin
      pair_d = '0;
    end else if (ctl_i.pop) begin
      pair_d.a = pair_q.b;
      pair_d.b = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      since_q  <= '0;
      held_q   <= '0;
      long_q   <= 1'b0;
      pair_q   <= '0;
    end else begin
      pair_q <= pair_d;
      if (ctl_i.load) begin
        raw_q    <= raw_d;
        stable_q <= stable_d;
        since_q  <= since_d;
        held_q   <= held_d;
        long_q   <= long_d;
      end
    end
  end

endmodule

### rtl/core/button_debounce_press_classifier.sv
// Top level of the button debounce and press classifier: configuration registers,
// the row of button cells, the drain control and the output register. Depends on
// bdpc_pkg and bdpc_btn_cell.
`timescale 1ns / 1ps

// Each input beat is one millisecond tick carrying the active-low raw levels of the
// buttons. All button cells update their debounce and timing state in the cycle the
// tick is taken and park up to two events each in a chain that collapses toward
// button 0, one cell per cycle. Events leave through a registered output, at most
// four per tick, the last one marked with tlast. The next tick is taken only once
// the previous tick's events have all moved into the output register, so a tick
// that causes events holds off the next tick until then.

module button_debounce_press_classifier import bdpc_pkg::*; #(
  parameter int unsigned NUM_BUTTONS   = NUM_BUTTONS_DEF,
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // level_enc_button, level_aux_button
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // duration
  output logic [2:0]            m_axis_tuser,   // press_kind [2:1], which_button [0]
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SUM_W = $clog2(2 * NUM_BUTTONS + 1);

  cfg_t                   cfg_q;
  logic [NUM_BUTTONS-1:0] level;
  logic [NUM_BUTTONS-1:0] empty;
  logic [1:0]             count [NUM_BUTTONS];
  pair_t                  pair  [NUM_BUTTONS+1];
  cell_ctl_t              ctl   [NUM_BUTTONS];
  logic [SUM_W-1:0]       sum;
  logic [REM_W-1:0]       rem_q, rem_d, rem_load;
  logic                   load, pop, last, chain_empty;
  evt_t                   out_q;
  logic                   out_vld_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DEBOUNCE_RST;
      cfg_q.medium_ms   <= MEDIUM_RST;
      cfg_q.long_ms     <= LONG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_data_i[SINCE_W-1:0];
        CFG_MEDIUM:   cfg_q.medium_ms   <= cfg_data_i;
        CFG_LONG:     cfg_q.long_ms     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign load          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (rem_q == '0);
  assign pop           = pair[0].a.vld && (rem_q != '0) && (!out_vld_q || m_axis_tready);
  assign last          = (rem_q == REM_W'(1));
  assign chain_empty   = &empty;
  assign pair[NUM_BUTTONS] = '0;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_cell
    if (b < 2) begin : g_lvl
      assign level[b] = s_axis_tdata[b];
    end else begin : g_idle
      assign level[b] = 1'b1;
    end

    assign ctl[b].load  = load;
    assign ctl[b].flush = pop && last;
    assign ctl[b].pop   = (b == 0) ? pop : 1'b0;

    bdpc_btn_cell #(
      .CELL_IDX      (b),
      .DURATION_BITS (DURATION_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl[b]),
      .level_i       (level[b]),
      .cfg_i         (cfg_q),
      .upper_i       (pair[b+1]),
      .lower_empty_i ((b == 0) ? 1'b0 : empty[(b == 0) ? 0 : b-1]),
      .pair_o        (pair[b]),
      .empty_o       (empty[b]),
      .count_o       (count[b])
    );
  end

  always_comb begin
    sum = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      sum = sum + SUM_W'(count[b]);
    end
    rem_load = (32'(sum) > MAX_RES) ? REM_W'(MAX_RES) : REM_W'(sum);
  end

  always_comb begin
    rem_d = rem_q;
    priority if (load) begin
      rem_d = rem_load;
    end else if (pop) begin
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      if (pop) begin
        out_vld_q  <= 1'b1;
        out_last_q <= last;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= pair[0].a;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.dur;
  assign m_axis_tuser  = {out_q.kind, out_q.which};
  assign m_axis_tlast  = out_last_q;

  // Events still owed for the current tick always sit somewhere in the chain.
  a_rem_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == '0) == chain_empty)
    else $error("pending event count disagrees with chain occupancy");

  a_rem_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= REM_W'(MAX_RES))
    else $error("pending event count above the per-tick limit");

  a_down_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.kind == KIND_DOWN)) |-> (m_axis_tdata == '0))
    else $error("down event carries a nonzero duration");

endmodule

### sim/tb_button_debounce_press_classifier.sv
// Self-checking testbench for the button debounce and press classifier.
// Drives millisecond ticks and register writes, predicts every press event and
// checks each output beat in order. Depends on bdpc_pkg and the block's top level.
`timescale 1ns / 1ps

module tb_button_debounce_press_classifier;
  import bdpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0]   CFG_SPARE = 2'd3;
  localparam logic [SINCE_W-1:0]     QUIET_MAX = '1;
  localparam logic [DUR_FIELD_W-1:0] HELD_MAX  = '1;

  typedef struct {
    logic                   which;
    kind_e                  kind;
    logic [DUR_FIELD_W-1:0] dur;
    logic                   last;
  } press_evt_t;

  class press_scoreboard;
    logic [SINCE_W-1:0]     settle_ticks;
    logic [15:0]            medium_at;
    logic [15:0]            long_at;
    logic                   raw_lvl[2];
    logic                   stable_lvl[2];
    logic                   long_done[2];
    logic [SINCE_W-1:0]     quiet_cnt[2];
    logic [DUR_FIELD_W-1:0] hold_cnt[2];
    press_evt_t             tick_evs[$];
    press_evt_t             due_q[$];
    int                     errors;
    int                     checked;

    function new();
      settle_ticks = DEBOUNCE_RST;
      medium_at    = MEDIUM_RST;
      long_at      = LONG_RST;
      for (int b = 0; b < 2; b++) begin
        raw_lvl[b]    = 1'b0;
        stable_lvl[b] = 1'b0;
        long_done[b]  = 1'b0;
        quiet_cnt[b]  = '0;
        hold_cnt[b]   = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      unique case (idx)
        CFG_DEBOUNCE: settle_ticks = data[SINCE_W-1:0];
        CFG_MEDIUM:   medium_at = data;
        CFG_LONG:     long_at = data;
        default: ;
      endcase
    endfunction

    function void add_evt(int b, kind_e k, logic [DUR_FIELD_W-1:0] d);
      press_evt_t ev;
      if (tick_evs.size() < MAX_RES) begin
        ev.which = b[0];
        ev.kind  = k;
        ev.dur   = d;
        ev.last  = 1'b0;
        tick_evs.push_back(ev);
      end
    endfunction

    function void note_tick(logic [1:0] lv);
      logic now_pressed;
      tick_evs.delete();
      for (int b = 0; b < 2; b++) begin
        now_pressed = !lv[b];
        if (now_pressed != raw_lvl[b]) begin
          raw_lvl[b]   = now_pressed;
          quiet_cnt[b] = '0;
        end else if (quiet_cnt[b] != QUIET_MAX) begin
          quiet_cnt[b]++;
        end
        if (stable_lvl[b] && hold_cnt[b] != HELD_MAX) hold_cnt[b]++;
        if (quiet_cnt[b] >= settle_ticks && raw_lvl[b] != stable_lvl[b]) begin
          stable_lvl[b] = raw_lvl[b];
          if (stable_lvl[b]) begin
            hold_cnt[b]  = '0;
            long_done[b] = 1'b0;
            add_evt(b, KIND_DOWN, '0);
          end else if (!long_done[b]) begin
            add_evt(b, (hold_cnt[b] >= medium_at) ? KIND_MEDIUM : KIND_SHORT, hold_cnt[b]);
          end
        end
        if (stable_lvl[b] && !long_done[b] && hold_cnt[b] >= long_at) begin
          long_done[b] = 1'b1;
          add_evt(b, KIND_LONG, hold_cnt[b]);
        end
      end
      if (tick_evs.size() > 0) tick_evs[tick_evs.size() - 1].last = 1'b1;
      foreach (tick_evs[i]) due_q.push_back(tick_evs[i]);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_event(logic which, logic [1:0] kind, logic [DUR_FIELD_W-1:0] dur, logic last);
      press_evt_t want;
      checked++;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected event button %0d kind %0d duration %0d",
                                  which, kind, dur));
        return;
      end
      want = due_q.pop_front();
      if (which !== want.which)
        report_mismatch($sformatf("button %0d, predicted %0d", which, want.which));
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, predicted %0d", kind, want.kind));
      if (dur !== want.dur)
        report_mismatch($sformatf("duration %0d, predicted %0d", dur, want.dur));
      if (last !== want.last)
        report_mismatch($sformatf("tlast %0b, predicted %0b", last, want.last));
    endtask

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  press_scoreboard sb;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_request;
  int stall_left;
  int ticks_sent;
  int settings_used;

  button_debounce_press_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_event(m_axis_tuser[0], m_axis_tuser[2:1], m_axis_tdata, m_axis_tlast);
  end

  task automatic send_tick(input logic [1:0] lv);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, lv};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(lv);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_ticks(input logic [1:0] lv, input int n);
    repeat (n) send_tick(lv);
  endtask

  task automatic drain_and_rest();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] settle,
                               input logic [CFG_DATA_W-1:0] medium_thr,
                               input logic [CFG_DATA_W-1:0] long_hold);
    write_reg(CFG_DEBOUNCE, settle);
    write_reg(CFG_MEDIUM, medium_thr);
    write_reg(CFG_LONG, long_hold);
    settings_used++;
  endtask

  // Mostly clean presses and releases with some contact bounce, plus a few random ticks.
  task automatic random_ticks(input int n);
    int         run_left[2];
    logic [1:0] target;
    logic [1:0] lv;
    int         span;
    run_left = '{0, 0};
    target   = 2'b11;
    span     = int'(sb.settle_ticks) + 4 + ((sb.long_at < 24) ? int'(sb.long_at) : 24);
    repeat (n) begin
      for (int b = 0; b < 2; b++) begin
        if (run_left[b] == 0) begin
          if ($urandom_range(4) != 0) target[b] = ~target[b];
          run_left[b] = int'($urandom_range(1, span));
        end
        run_left[b]--;
        lv[b] = ($urandom_range(9) == 0) ? ~target[b] : target[b];
      end
      if ($urandom_range(14) == 0) lv = 2'($urandom_range(3));
      send_tick(lv);
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DEBOUNCE;
    cfg_data_i    = '0;
    src_idle_pct  = 24;
    sink_idle_pct = 45;
    hold_request  = 0;
    ticks_sent    = 0;
    settings_used = 1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values: both buttons pressed and released past the default debounce time.
    hold_ticks(2'b00, 52);
    hold_ticks(2'b11, 52);
    drain_and_rest();

    // Zero debounce and zero long time: four events in one tick, then a silent release.
    apply_setting(16'hFC00, 16'd2, 16'd0);
    send_tick(2'b00);
    send_tick(2'b11);
    drain_and_rest();

    apply_setting(16'd0, 16'd2, 16'd3);
    send_tick(2'b10);
    send_tick(2'b11);
    hold_ticks(2'b01, 3);
    send_tick(2'b11);
    hold_ticks(2'b10, 5);
    send_tick(2'b11);
    drain_and_rest();

    // A write to the unused index must change nothing.
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(CFG_DEBOUNCE, 16'd2);
    send_tick(2'b10);
    send_tick(2'b11);
    hold_ticks(2'b10, 3);
    send_tick(2'b11);
    send_tick(2'b10);
    hold_ticks(2'b11, 3);
    drain_and_rest();

    // Largest settings, then a zero medium threshold.
    apply_setting(16'h03FF, 16'hFFFF, 16'hFFFF);
    hold_ticks(2'b10, 8);
    hold_ticks(2'b11, 8);
    drain_and_rest();
    apply_setting(16'd1, 16'd0, 16'hFFFF);
    random_ticks(15);
    drain_and_rest();

    for (int m = 0; m < 3; m++) begin
      src_idle_pct  = (m == 0) ? 24 : (m == 1) ? 45 : 0;
      sink_idle_pct = (m == 0) ? 45 : (m == 1) ? 24 : 0;
      repeat (2) begin
        apply_setting(16'($urandom_range(0, 4)), 16'($urandom_range(0, 10)),
                      ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 16)));
        random_ticks(10);
        drain_and_rest();
      end
    end

    // Long output hold while ticks keep coming, so the block backs up and stalls its input.
    apply_setting(16'd0, 16'd5, 16'd0);
    hold_request = 300;
    repeat (8) begin
      send_tick(2'b00);
      send_tick(2'b11);
    end
    drain_and_rest();
    repeat (20) @(negedge clk_i);

    $display("Summary: %0d ticks driven, %0d button events checked under %0d register settings,",
             ticks_sent, sb.checked, settings_used);
    $display("with both sides stalling, a long output hold and the extreme register values.");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
